// ===== design/lmbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lmbs_pkg
// shared sizes, blink timing constants and phase helpers for the led scan block
// ----------------------------------------------------------------------------
package lmbs_pkg;

	localparam int ROWS = 6;
	localparam int COLS = 8;

	// fixed field widths
	localparam int REQ_W   = 1;
	localparam int IDX_W   = 3;
	localparam int WORD_W  = 16;
	localparam int TIME_W  = 16;
	localparam int LEVEL_W = 8;

	// row pointer width, at least one bit
	localparam int ROW_SEL_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	localparam logic [LEVEL_W-1:0] COL_MASK = LEVEL_W'((1 << COLS) - 1);
	localparam logic [LEVEL_W-1:0] LEVEL_MASK = LEVEL_W'(16'h00FF);

	// blink timing
	localparam int SLOW_PERIOD = 6554;
	localparam int SLOW_HALF   = 3277;
	localparam int FAST_PERIOD = 1310;
	localparam int FAST_HALF   = 655;

	// coarse step for the fast phase: ten fast periods
	localparam int COARSE_PERIOD = 10 * FAST_PERIOD;
	localparam int COARSE_STEPS  = ((1 << TIME_W) - 1) / COARSE_PERIOD;
	localparam int SLOW_STEPS    = ((1 << TIME_W) - 1) / SLOW_PERIOD;
	localparam int FAST_STEPS    = COARSE_PERIOD / FAST_PERIOD - 1;
	localparam int COARSE_W      = $clog2(COARSE_PERIOD);

	typedef enum logic [REQ_W-1:0] {
		REQ_WRITE = 1'b0,
		REQ_TICK  = 1'b1
	} req_type_t;

	// time reduced modulo ten fast periods
	function automatic logic [COARSE_W-1:0] coarse_mod(input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] base;
		base = '0;
		for (int k = 1; k <= COARSE_STEPS; k++) begin
			if (t >= TIME_W'(k * COARSE_PERIOD))
				base = TIME_W'(k * COARSE_PERIOD);
		end
		return COARSE_W'(t - base);
	endfunction

	// on half of the fast phase, from the coarse residue
	function automatic logic fast_on(input logic [COARSE_W-1:0] r);
		logic [COARSE_W-1:0] base;
		base = '0;
		for (int k = 1; k <= FAST_STEPS; k++) begin
			if (r >= COARSE_W'(k * FAST_PERIOD))
				base = COARSE_W'(k * FAST_PERIOD);
		end
		return (r - base) <= COARSE_W'(FAST_HALF);
	endfunction

	// on half of the slow phase
	function automatic logic slow_on(input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] base;
		base = '0;
		for (int k = 1; k <= SLOW_STEPS; k++) begin
			if (t >= TIME_W'(k * SLOW_PERIOD))
				base = TIME_W'(k * SLOW_PERIOD);
		end
		return (t - base) <= TIME_W'(SLOW_HALF);
	endfunction

endpackage

// ===== design/led_matrix_blink_scan.sv =====
// ----------------------------------------------------------------------------
// led_matrix_blink_scan
// multiplexed led matrix driver with steady, slow blink and fast blink columns
// ----------------------------------------------------------------------------
// The block holds one 16-bit word per led row (low byte: steady levels, active
// low; high byte: blink enables). A write word (req_type 0) stores state_word
// into row row_index, or is dropped when the row is out of range, and gives no
// result. A tick word (req_type 1) gives one result: the expander word for the
// current scan row, with a one-hot row select at bit 8 + row and the lit column
// bits in 0 to 7, and then the scan row steps on and wraps. One word is taken
// every clock cycle as long as results are taken; input only stalls while a
// tick sits in the input register behind a held result. A tick taken is
// latched in the input register; its result is loaded into the result register
// when that register is empty or taken, and shows on the outputs from there. Row
// store and scan pointer are updated at accept time, so a tick right after a
// write sees it. Reset clears all row words and the scan pointer.
module led_matrix_blink_scan
	import lmbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [IDX_W-1:0]     row_index,
	input  logic [WORD_W-1:0]    state_word,
	input  logic [TIME_W-1:0]    time_now,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [WORD_W-1:0]    expander_word,
	output logic [IDX_W-1:0]     scan_row_out
);

	// row store and scan pointer
	logic [WORD_W-1:0]    row_states_q [ROWS];
	logic [ROW_SEL_W-1:0] scan_row_q;

	// input register (tick words only)
	logic                 tick_s1;
	logic [WORD_W-1:0]    word_s1;
	logic [TIME_W-1:0]    time_s1;
	logic [COARSE_W-1:0]  coarse_s1;
	logic [ROW_SEL_W-1:0] row_s1;

	// result register
	logic                 out_valid_q;
	logic [WORD_W-1:0]    expander_word_q;
	logic [IDX_W-1:0]     scan_row_out_q;

	logic in_fire;
	logic is_tick;
	logic is_write;
	logic row_ok;
	logic adv_s1;

	logic [LEVEL_W-1:0] level;
	logic [LEVEL_W-1:0] blink_en;
	logic [LEVEL_W-1:0] slow_mask;
	logic [LEVEL_W-1:0] fast_mask;
	logic [LEVEL_W-1:0] columns;
	logic [LEVEL_W-1:0] row_sel;

	// result register frees when empty or taken; s1 moves on when it does
	assign adv_s1   = !out_valid_q || out_ready;
	assign in_ready = !tick_s1 || adv_s1;
	assign in_fire  = in_valid && in_ready;
	assign is_tick  = (req_type_t'(req_type) == REQ_TICK);
	assign is_write = (req_type_t'(req_type) == REQ_WRITE);
	// rows of ROWS or more are dropped
	assign row_ok   = ({1'b0, row_index} < (IDX_W + 1)'(ROWS));

	// row store writes and scan pointer advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS; i++)
				row_states_q[i] <= '0;
			scan_row_q <= '0;
		end else if (in_fire) begin
			if (is_write && row_ok)
				row_states_q[row_index[ROW_SEL_W-1:0]] <= state_word;
			if (is_tick) begin
				if (scan_row_q == ROW_SEL_W'(ROWS - 1))
					scan_row_q <= '0;
				else
					scan_row_q <= scan_row_q + 1'b1;
			end
		end
	end

	// input register: tick flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tick_s1 <= 1'b0;
		else if (in_ready)
			tick_s1 <= in_fire && is_tick;
	end

	// input register: payload, with the coarse time reduction done up front
	always_ff @(posedge clk) begin
		if (in_fire && is_tick) begin
			word_s1   <= row_states_q[scan_row_q];
			time_s1   <= time_now;
			coarse_s1 <= coarse_mod(time_now);
			row_s1    <= scan_row_q;
		end
	end

	// column logic
	always_comb begin
		level     = word_s1[LEVEL_W-1:0] & LEVEL_MASK;
		blink_en  = word_s1[WORD_W-1:LEVEL_W];
		slow_mask = {LEVEL_W{slow_on(time_s1)}};
		fast_mask = {LEVEL_W{fast_on(coarse_s1)}};
		// steady on, slow blink on clear level, fast blink on set level
		columns   = ((~blink_en & ~level)
			| (blink_en & ~level & slow_mask)
			| (blink_en & level & fast_mask)) & COL_MASK;
		row_sel   = LEVEL_W'(1) << row_s1;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv_s1)
			out_valid_q <= tick_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && tick_s1) begin
			expander_word_q <= {row_sel, columns};
			scan_row_out_q  <= IDX_W'(row_s1);
		end
	end

	assign out_valid     = out_valid_q;
	assign expander_word = expander_word_q;
	assign scan_row_out  = scan_row_out_q;

`ifndef ASSERT_OFF
	// scan pointer stays inside the row range
	assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, scan_row_q} < (ROW_SEL_W + 1)'(ROWS))
		else $error("scan pointer out of range");

	// row select matches the reported row
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (expander_word[WORD_W-1:LEVEL_W] == (LEVEL_W'(1) << scan_row_out)))
		else $error("row select does not match scan row");

	// input only stalls behind a held result
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (tick_s1 && out_valid && !out_ready))
		else $error("input stalled without output back pressure");

	// a write word never produces a result
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && is_write) |=> !tick_s1)
		else $error("write word entered the result path");
`endif

endmodule
